// ===== src/frls_pkg.sv =====
// Shared types, constants and helpers for the frame luma / red region stats block.
// No dependencies; imported by frls_stats and the top level.
`default_nettype none
package frls_pkg;

    // Default frame size limits handed to the top level parameters
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Width of an effective frame size; holds the largest allowed limit
    localparam int SIZE_W = 17;

    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_OUT_W  = 12;
    localparam int COUNT_W    = 25;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 72;

    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST   = 13'd640;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST  = 13'd480;
    localparam logic [7:0]         RED_FLOOR_RST     = 8'd120;
    localparam logic [7:0]         OTHER_CEILING_RST = 8'd90;
    localparam logic [7:0]         LUMA_MIN_RST      = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_SAT         = 25'h1FFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_RED_FLOOR     = 2'd2,
        REG_OTHER_CEILING = 2'd3
    } frls_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [7:0]       red_floor;
        logic [7:0]       other_ceiling;
    } frls_cfg_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] red_last_row;
        logic [ROW_OUT_W-1:0] red_first_row;
        logic                 red_found;
        logic [COUNT_W-1:0]   red_count;
        logic [7:0]           luma_max;
        logic [7:0]           luma_min;
    } frls_result_t;

    // (r+g+b)/3 as multiply by 683/2048; exact for sums up to 765
    function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [9:0]  sum;
        logic [20:0] prod;
        sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
        prod = {11'd0, sum} * 21'd683;
        return prod[18:11];
    endfunction

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
        logic [SIZE_W-1:0] ext;
        ext = {{(SIZE_W-CFG_W){1'b0}}, v};
        if (ext == '0)
            return {{(SIZE_W-1){1'b0}}, 1'b1};
        else if (ext > limit)
            return limit;
        else
            return ext;
    endfunction

endpackage
`default_nettype wire

// ===== src/frls_stats.sv =====
// Per-frame statistics state: position counters, luma min/max, red pixel tracking.
// Depends on frls_pkg. Result and frame end are combinational over state plus current pixel.
`default_nettype none
module frls_stats #(
    parameter int MAX_WIDTH  = frls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frls_pkg::MAX_HEIGHT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  wire [7:0]            pixel_red,
    input  wire [7:0]            pixel_green,
    input  wire [7:0]            pixel_blue,
    input  frls_pkg::frls_cfg_t  cfg,
    output logic                 frame_end,
    output frls_pkg::frls_result_t result
);
    import frls_pkg::*;

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [SIZE_W-1:0] WIDTH_LIM  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_LIM = SIZE_W'(MAX_HEIGHT);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [7:0]         min_reg, min_next;
    logic [7:0]         max_reg, max_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               seen_reg, seen_next;
    logic [ROW_W-1:0]   first_reg, first_next;
    logic [ROW_W-1:0]   last_reg, last_next;

    logic [7:0]          luma;
    logic                red_hit;
    logic                row_end;
    logic [SIZE_W-1:0]   last_col;
    logic [SIZE_W-1:0]   last_row;
    logic [ROW_W+11:0]   first_ext;
    logic [ROW_W+11:0]   last_ext;

    always_comb
    begin
        luma     = luma_of(pixel_red, pixel_green, pixel_blue);
        red_hit  = (pixel_red > cfg.red_floor) && (pixel_green < cfg.other_ceiling)
                   && (pixel_blue < cfg.other_ceiling);
        last_col = eff_size(cfg.frame_width, WIDTH_LIM) - SIZE_W'(1);
        last_row = eff_size(cfg.frame_height, HEIGHT_LIM) - SIZE_W'(1);
        row_end  = {{(SIZE_W-COL_W){1'b0}}, col_reg} >= last_col;
        frame_end = row_end && ({{(SIZE_W-ROW_W){1'b0}}, row_reg} >= last_row);

        // statistics including the current pixel
        min_next   = (luma < min_reg) ? luma : min_reg;
        max_next   = (luma > max_reg) ? luma : max_reg;
        total_next = (red_hit && total_reg != COUNT_SAT) ? total_reg + COUNT_W'(1)
                                                         : total_reg;
        first_next = (red_hit && !seen_reg) ? row_reg : first_reg;
        last_next  = red_hit ? row_reg : last_reg;
        seen_next  = seen_reg | red_hit;

        first_ext = {12'd0, first_next};
        last_ext  = {12'd0, last_next};

        result.luma_min      = min_next;
        result.luma_max      = max_next;
        result.red_count     = total_next;
        result.red_found     = seen_next;
        result.red_first_row = seen_next ? first_ext[ROW_OUT_W-1:0] : '0;
        result.red_last_row  = seen_next ? last_ext[ROW_OUT_W-1:0] : '0;

        if (row_end)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            min_reg   <= LUMA_MIN_RST;
            max_reg   <= '0;
            total_reg <= '0;
            seen_reg  <= 1'b0;
            first_reg <= '0;
            last_reg  <= '0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                // result leaves with this pixel; start the next frame clean
                col_reg   <= '0;
                row_reg   <= '0;
                min_reg   <= LUMA_MIN_RST;
                max_reg   <= '0;
                total_reg <= '0;
                seen_reg  <= 1'b0;
                first_reg <= '0;
                last_reg  <= '0;
            end
            else
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                total_reg <= total_next;
                seen_reg  <= seen_next;
                first_reg <= first_next;
                last_reg  <= last_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/frame_luma_and_red_region_stats.sv =====
// Top level of the frame luma and red region statistics block.
// Depends on frls_pkg and frls_stats; holds the config registers and the channel stages.
//
// Usage:
//   s_* channel: one RGB pixel per word, raster order, frame size from config.
//   m_* channel: one word per frame, issued with the frame's last pixel.
//   cfg_*: register writes, taken at any edge with cfg_write high; write only
//   while no frame is in flight.
// Timing:
//   A pixel is held in the input register, then updates the frame
//   statistics; the frame result is then held in the output register that
//   drives m_tvalid. One pixel per clock is sustained unless a final pixel
//   waits (see Stalls); the statistics update is a loop of adds and compares.
// Stalls:
//   Non-final pixels never wait on m_tready. A final pixel waits in the
//   input register only while the previous result is still held unread,
//   and s_tready drops for that time.
// Reset:
//   rst_n clears all frame state and both channel stages and returns the
//   registers to 640 x 480, red floor 120, other ceiling 90.
`default_nettype none
module frame_luma_and_red_region_stats #(
    parameter int MAX_WIDTH  = frls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frls_pkg::MAX_HEIGHT_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
    input  wire [frls_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // luma_min [7:0], luma_max [15:8], red_count [40:16], red_found [41],
    // red_first_row [53:42], red_last_row [65:54], zeros [71:66]
    output logic [frls_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire                              cfg_write,
    input  wire [frls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [frls_pkg::CFG_W-1:0]        cfg_data
);
    import frls_pkg::*;

    frls_cfg_t     cfg_reg;
    logic          pix_valid_reg;
    logic [7:0]    red_reg, green_reg, blue_reg;
    logic          out_valid_reg;
    frls_result_t  out_reg;

    logic          frame_end;
    frls_result_t  result;
    logic          step;
    logic          out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= FRAME_HEIGHT_RST;
            cfg_reg.red_floor     <= RED_FLOOR_RST;
            cfg_reg.other_ceiling <= OTHER_CEILING_RST;
        end
        else if (cfg_write)
        begin
            unique case (frls_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data;
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data;
                REG_RED_FLOOR:     cfg_reg.red_floor     <= cfg_data[7:0];
                REG_OTHER_CEILING: cfg_reg.other_ceiling <= cfg_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // hold a final pixel only while the previous result is still unread
    assign step     = pix_valid_reg && !(frame_end && out_valid_reg && !m_tready);
    assign out_load = step && frame_end;
    assign s_tready = !pix_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (s_tready)
            pix_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            red_reg   <= s_tdata[7:0];
            green_reg <= s_tdata[15:8];
            blue_reg  <= s_tdata[23:16];
        end
    end

    frls_stats #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pixel_red   (red_reg),
        .pixel_green (green_reg),
        .pixel_blue  (blue_reg),
        .cfg         (cfg_reg),
        .frame_end   (frame_end),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(frls_result_t)){1'b0}}, out_reg};

endmodule
`default_nettype wire

// ===== sim/frame_luma_and_red_region_stats_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for frame_luma_and_red_region_stats: pixel stream in, frame stats out.
// Depends on frls_pkg for register codes and the result word layout.
module frame_luma_and_red_region_stats_test;
    import frls_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 460;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_PIXELS
    } step_kind_t;

    typedef struct {
        step_kind_t   kind;
        frls_reg_t    idx;
        logic [12:0]  value;
        logic [7:0]   r;
        logic [7:0]   g;
        logic [7:0]   b;
        int           reps;
        bit           typed;
        frls_result_t want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int send_idle_pct  = 12;
    int recv_stall_pct = 65;
    int mismatch_count = 0;

    // Predictor copy of the registers
    logic [12:0] dim_w_set     = 13'd640;
    logic [12:0] dim_h_set     = 13'd480;
    logic [7:0]  red_floor_set = 8'd120;
    logic [7:0]  ceiling_set   = 8'd90;

    // Predictor copy of the frame state
    int          col_pos       = 0;
    int          row_pos       = 0;
    logic [7:0]  luma_lo       = 8'd255;
    logic [7:0]  luma_hi       = 8'd0;
    logic [24:0] red_pixels    = '0;
    bit          red_seen      = 1'b0;
    logic [11:0] red_row_first = '0;
    logic [11:0] red_row_last  = '0;

    frls_result_t frame_results_q[$];
    plan_row_t    plan[$];

    frame_luma_and_red_region_stats i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic int clamp_dim(input logic [12:0] v, input int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic frls_result_t mk_result(input int lo, input int hi, input int cnt,
                                               input int found, input int first,
                                               input int last);
        frls_result_t res;
        res               = '0;
        res.luma_min      = 8'(lo);
        res.luma_max      = 8'(hi);
        res.red_count     = 25'(cnt);
        res.red_found     = 1'(found);
        res.red_first_row = 12'(first);
        res.red_last_row  = 12'(last);
        return res;
    endfunction

    function automatic void plan_write(input frls_reg_t idx, input logic [12:0] v);
        plan_row_t row;
        row  = '{STEP_WRITE, idx, v, 8'd0, 8'd0, 8'd0, 0, 1'b0, '0};
        plan = {plan, row};
    endfunction

    function automatic void plan_pix(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input int reps, input bit typed,
                                     input frls_result_t want);
        plan_row_t row;
        row  = '{STEP_PIXELS, REG_FRAME_WIDTH, 13'd0, r, g, b, reps, typed, want};
        plan = {plan, row};
    endfunction

    function automatic logic [12:0] random_dim();
        case ($urandom_range(0, 15))
            0:       return 13'd0;
            1:       return 13'($urandom_range(7, 24));
            default: return 13'($urandom_range(1, 5));
        endcase
    endfunction

    // Threshold in the low byte, junk in the unused upper bits
    function automatic logic [12:0] random_level();
        logic [7:0] lvl;
        case ($urandom_range(0, 5))
            0:       lvl = 8'd0;
            1:       lvl = 8'd255;
            default: lvl = 8'($urandom_range(40, 200));
        endcase
        return {5'($urandom_range(0, 31)), lvl};
    endfunction

    task automatic stats_advance(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, output bit done,
                                 output frls_result_t res);
        int lum;
        int w;
        int h;
        bit row_end;
        lum = (int'(r) + int'(g) + int'(b)) / 3;
        w   = clamp_dim(dim_w_set, MAX_W);
        h   = clamp_dim(dim_h_set, MAX_H);
        if (lum < luma_lo)
            luma_lo = 8'(lum);
        if (lum > luma_hi)
            luma_hi = 8'(lum);
        if (r > red_floor_set && g < ceiling_set && b < ceiling_set)
        begin
            if (red_pixels != COUNT_SAT)
                red_pixels++;
            if (!red_seen)
                red_row_first = 12'(row_pos);
            red_row_last = 12'(row_pos);
            red_seen     = 1'b1;
        end
        // A shrunken size ends the row or frame on whatever position is already past it
        row_end = (col_pos >= w - 1);
        done    = row_end && (row_pos >= h - 1);
        res     = '0;
        if (done)
        begin
            res.luma_min      = luma_lo;
            res.luma_max      = luma_hi;
            res.red_count     = red_pixels;
            res.red_found     = red_seen;
            res.red_first_row = red_seen ? red_row_first : 12'd0;
            res.red_last_row  = red_seen ? red_row_last : 12'd0;
            col_pos       = 0;
            row_pos       = 0;
            luma_lo       = 8'd255;
            luma_hi       = 8'd0;
            red_pixels    = '0;
            red_seen      = 1'b0;
            red_row_first = '0;
            red_row_last  = '0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input bit typed, input frls_result_t want);
        bit           done;
        frls_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        stats_advance(r, g, b, done, predicted);
        if (done)
            frame_results_q = {frame_results_q, (typed ? want : predicted)};
    endtask

    // Hold the stream until every pending frame word has come out and the pipe is empty
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (frame_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input frls_reg_t idx, input logic [12:0] v);
        settle_block();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:   dim_w_set     = v;
            REG_FRAME_HEIGHT:  dim_h_set     = v;
            REG_RED_FLOOR:     red_floor_set = v[7:0];
            REG_OTHER_CEILING: ceiling_set   = v[7:0];
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        frls_result_t got;
        frls_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(frls_result_t)-1:0];
            if (frame_results_q.size() == 0)
            begin
                $error("frame word with no frame pending");
                mismatch_count++;
            end
            else
            begin
                want = frame_results_q.pop_front();
                check_field("luma_min", 32'(want.luma_min), 32'(got.luma_min));
                check_field("luma_max", 32'(want.luma_max), 32'(got.luma_max));
                check_field("red_count", 32'(want.red_count), 32'(got.red_count));
                check_field("red_found", 32'(want.red_found), 32'(got.red_found));
                check_field("red_first_row", 32'(want.red_first_row),
                            32'(got.red_first_row));
                check_field("red_last_row", 32'(want.red_last_row),
                            32'(got.red_last_row));
                check_field("pad", 32'd0,
                            32'(m_tdata[OUT_DATA_W-1:$bits(frls_result_t)]));
            end
        end
    end

    initial
    begin
        int          n;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;

        // Row 0 ends after 640 pixels at reset size, later rows after one (width 1); the frame ends after 480 rows.
        // Red sits on the last pixel of row 0 and on the frame's last pixel.
        plan_pix(8'd120, 8'd89, 8'd89, 639, 1'b0, '0);
        plan_pix(8'd121, 8'd89, 8'd89, 1, 1'b0, '0);
        plan_write(REG_FRAME_WIDTH, 13'd1);
        plan_pix(8'd120, 8'd89, 8'd89, 478, 1'b0, '0);
        plan_pix(8'd121, 8'd89, 8'd89, 1, 1'b1, mk_result(99, 99, 2, 1, 0, 479));

        plan_write(REG_FRAME_WIDTH, 13'd1);
        plan_write(REG_FRAME_HEIGHT, 13'd1);
        plan_pix(8'd0, 8'd0, 8'd0, 1, 1'b1, mk_result(0, 0, 0, 0, 0, 0));
        plan_pix(8'd255, 8'd255, 8'd255, 1, 1'b1, mk_result(255, 255, 0, 0, 0, 0));
        // Thresholds are strict on both sides
        plan_pix(8'd121, 8'd89, 8'd89, 1, 1'b1, mk_result(99, 99, 1, 1, 0, 0));
        plan_pix(8'd120, 8'd89, 8'd89, 1, 1'b1, mk_result(99, 99, 0, 0, 0, 0));
        plan_pix(8'd121, 8'd90, 8'd89, 1, 1'b0, '0);
        plan_pix(8'd121, 8'd89, 8'd90, 1, 1'b0, '0);

        plan_write(REG_RED_FLOOR, 13'd0);
        plan_write(REG_OTHER_CEILING, 13'h1FFF);
        plan_pix(8'd1, 8'd254, 8'd254, 1, 1'b0, '0);
        plan_pix(8'd0, 8'd0, 8'd0, 1, 1'b0, '0);
        plan_write(REG_RED_FLOOR, 13'd255);
        plan_pix(8'd255, 8'd0, 8'd0, 1, 1'b1, mk_result(85, 85, 0, 0, 0, 0));
        plan_write(REG_RED_FLOOR, 13'd0);
        plan_write(REG_OTHER_CEILING, 13'd0);
        plan_pix(8'd255, 8'd0, 8'd0, 1, 1'b0, '0);

        // Zero sizes act as one pixel per frame
        plan_write(REG_FRAME_WIDTH, 13'd0);
        plan_write(REG_FRAME_HEIGHT, 13'd0);
        plan_pix(8'd10, 8'd20, 8'd30, 1, 1'b1, mk_result(20, 20, 0, 0, 0, 0));

        plan_write(REG_RED_FLOOR, 13'd120);
        plan_write(REG_OTHER_CEILING, 13'd90);
        plan_write(REG_FRAME_WIDTH, 13'd2);
        plan_write(REG_FRAME_HEIGHT, 13'd2);
        plan_pix(8'd255, 8'd0, 8'd0, 1, 1'b0, '0);
        plan_pix(8'd0, 8'd0, 8'd0, 2, 1'b0, '0);
        plan_pix(8'd200, 8'd50, 8'd50, 1, 1'b0, '0);

        // Oversized width and height do not end the row or frame early
        plan_write(REG_FRAME_WIDTH, 13'h1FFF);
        plan_write(REG_FRAME_HEIGHT, 13'd1);
        plan_pix(8'd0, 8'd0, 8'd0, 40, 1'b0, '0);
        plan_write(REG_FRAME_WIDTH, 13'd4);
        plan_pix(8'd255, 8'd255, 8'd255, 1, 1'b1, mk_result(0, 255, 0, 0, 0, 0));
        plan_write(REG_FRAME_WIDTH, 13'd1);
        plan_write(REG_FRAME_HEIGHT, 13'h1FFF);
        plan_pix(8'd0, 8'd0, 8'd0, 40, 1'b0, '0);
        plan_write(REG_FRAME_HEIGHT, 13'd2);
        plan_pix(8'd255, 8'd0, 8'd0, 1, 1'b1, mk_result(0, 85, 1, 1, 40, 40));

        // Shrink the size mid-frame, past the current column, then the current row
        plan_write(REG_FRAME_WIDTH, 13'd8);
        plan_write(REG_FRAME_HEIGHT, 13'd2);
        plan_pix(8'd50, 8'd50, 8'd50, 5, 1'b0, '0);
        plan_write(REG_FRAME_WIDTH, 13'd3);
        plan_pix(8'd255, 8'd0, 8'd0, 1, 1'b0, '0);
        plan_pix(8'd130, 8'd20, 8'd20, 3, 1'b0, '0);
        plan_write(REG_FRAME_WIDTH, 13'd2);
        plan_write(REG_FRAME_HEIGHT, 13'd8);
        plan_pix(8'd140, 8'd60, 8'd70, 6, 1'b0, '0);
        plan_write(REG_FRAME_HEIGHT, 13'd2);
        plan_pix(8'd30, 8'd40, 8'd50, 2, 1'b0, '0);

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_WRITE)
                write_reg(plan[i].idx, plan[i].value);
            else
                for (int k = 0; k < plan[i].reps; k++)
                    send_pixel(plan[i].r, plan[i].g, plan[i].b,
                               plan[i].typed && (k == plan[i].reps - 1), plan[i].want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 65;
                recv_stall_pct = 12;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            if (col_pos == 0 && row_pos == 0 && $urandom_range(0, 2) == 0)
            begin
                write_reg(REG_FRAME_WIDTH, random_dim());
                write_reg(REG_FRAME_HEIGHT, random_dim());
                if ($urandom_range(0, 1))
                    write_reg(REG_RED_FLOOR, random_level());
                if ($urandom_range(0, 1))
                    write_reg(REG_OTHER_CEILING, random_level());
            end
            else if ($urandom_range(0, 149) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH,
                          random_dim());
            end

            case ($urandom_range(0, 3))
                1:
                begin
                    r = 8'($urandom_range(130, 255));
                    g = 8'($urandom_range(0, 95));
                    b = 8'($urandom_range(0, 95));
                end
                2:
                begin
                    // Sit on the thresholds: red one step either side, green and blue on the ceiling or one below
                    r = red_floor_set + 8'($urandom_range(0, 2)) - 8'd1;
                    g = ceiling_set - 8'($urandom_range(0, 1));
                    b = ceiling_set - 8'($urandom_range(0, 1));
                end
                default:
                begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
            endcase
            send_pixel(r, g, b, 1'b0, '0);
        end

        settle_block();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
